### rtl/core/brbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brbp_pkg
// Shared types and constants of the byte ring buffer with prepend.
// ----------------------------------------------------------------------------
package brbp_pkg;

  // default number of store entries
  localparam int unsigned BrbpDepthDefault = 256;

  // width and reset value of the size register
  localparam int unsigned SizeWidth = 9;
  localparam logic [SizeWidth-1:0] SizeReset = 9'd256;

  // command codes
  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_PREPEND = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

endpackage : brbp_pkg
`default_nettype wire

### rtl/core/byte_ring_buffer_with_prepend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_prepend
// Circular byte deque: append at back, prepend at front, read from front,
// clear. Every command item gives one result item with status and counts.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  input    | in_valid_i / in_ready_o | cmd_i, byte_in_i
//  result   | out_valid_o/out_ready_i | byte_out_o, status_o, fill_count_o,
//           |                         | space_count_o
//  config   | cfg_we_i                | cfg_wdata_i (size_in_use)
//
//  one item is accepted per cycle while in_ready_o is high; its result is
//  registered in the first result slot and then moves to the output register
//  once that register is empty or out_ready_i takes the result it holds
//  reset clears the indices and sets size_in_use to 256; store is not cleared
//  two result slots, the second of which drives the outputs, so an item is
//  still taken while one result waits; in_ready_o drops only when both slots
//  hold results and out_ready_i is low
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_prepend
  import brbp_pkg::*;
#(
  parameter int unsigned DEPTH = BrbpDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [SizeWidth-1:0] cfg_wdata_i,
  // command items
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [7:0]           byte_in_i,
  // result items
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                byte_out_o,
  output logic [1:0]                status_o,
  output logic [7:0]                fill_count_o,
  output logic [7:0]                space_count_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned SW = (CW > SizeWidth) ? CW : SizeWidth;

  // state
  logic [SizeWidth-1:0] size_q;
  logic [IW-1:0]        wr_idx_q, wr_idx_d;
  logic [IW-1:0]        rd_idx_q, rd_idx_d;
  logic [7:0]           store_q [DEPTH];
  logic [7:0]           rdata_q;

  // first result slot
  logic       s1_valid_q;
  logic       s1_rd_ok_q;
  status_e    s1_status_q;
  logic [7:0] s1_fill_q;
  logic [7:0] s1_space_q;

  // second result slot (output register)
  logic       s2_valid_q;
  logic [7:0] s2_byte_q;
  status_e    s2_status_q;
  logic [7:0] s2_fill_q;
  logic [7:0] s2_space_q;

  logic       accept;
  logic       s1_move;
  cmd_e       cmd;
  logic [SW-1:0] size_ext;
  logic [CW-1:0] sz;
  logic [CW-1:0] fill_cur, space_cur;
  logic [CW-1:0] fill_nxt, space_nxt;
  logic [CW+7:0] fill_wide, space_wide;
  logic          empty;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          rd_ok;
  status_e       status_n;
  logic [CW-1:0] wr_inc, rd_inc;

  // handshake
  assign s1_move    = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !s2_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(cmd_i);

  // effective size, clamped to 1..DEPTH
  always_comb begin
    size_ext = SW'(size_q);
    if (size_ext == '0) begin
      sz = CW'(1);
    end else if (size_ext > SW'(DEPTH)) begin
      sz = CW'(DEPTH);
    end else begin
      sz = CW'(size_ext);
    end
  end

  // fill and space before the command
  assign empty = (wr_idx_q == rd_idx_q);
  always_comb begin
    if (wr_idx_q >= rd_idx_q) begin
      fill_cur = CW'(wr_idx_q) - CW'(rd_idx_q);
    end else begin
      fill_cur = sz - CW'(rd_idx_q) + CW'(wr_idx_q);
    end
    space_cur = sz - CW'(1) - fill_cur;
  end

  // index increments, wrapped to zero on reaching sz where they are used
  assign wr_inc = CW'(wr_addr) + CW'(1);
  assign rd_inc = CW'(rd_idx_q) + CW'(1);

  // command decode and next indices
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    wr_en    = 1'b0;
    wr_addr  = empty ? '0 : wr_idx_q;
    rd_ok    = 1'b0;
    status_n = STAT_OK;
    unique case (cmd)
      CMD_APPEND: begin
        if (space_cur == '0) begin
          status_n = STAT_FULL;
        end else begin
          wr_en    = 1'b1;
          rd_idx_d = empty ? '0 : rd_idx_q;
          wr_idx_d = (wr_inc == sz) ? '0 : IW'(wr_inc);
        end
      end
      CMD_PREPEND: begin
        if (space_cur == '0) begin
          status_n = STAT_FULL;
        end else begin
          wr_en = 1'b1;
          if (empty) begin
            wr_idx_d = '0;
            rd_idx_d = IW'(sz - CW'(1));
          end else if (rd_idx_q == '0) begin
            rd_idx_d = IW'(sz - CW'(1));
          end else begin
            rd_idx_d = rd_idx_q - IW'(1);
          end
          wr_addr = rd_idx_d;
        end
      end
      CMD_READ: begin
        if (empty) begin
          status_n = STAT_EMPTY;
        end else begin
          rd_ok    = 1'b1;
          rd_idx_d = (rd_inc == sz) ? '0 : IW'(rd_inc);
        end
      end
      CMD_CLEAR: begin
        wr_idx_d = '0;
        rd_idx_d = '0;
      end
      default: begin
        wr_idx_d = wr_idx_q;
        rd_idx_d = rd_idx_q;
      end
    endcase
  end

  // fill and space after the command
  always_comb begin
    if (wr_idx_d >= rd_idx_d) begin
      fill_nxt = CW'(wr_idx_d) - CW'(rd_idx_d);
    end else begin
      fill_nxt = sz - CW'(rd_idx_d) + CW'(wr_idx_d);
    end
    space_nxt  = sz - CW'(1) - fill_nxt;
    fill_wide  = (CW+8)'(fill_nxt);
    space_wide = (CW+8)'(space_nxt);
  end

  // byte store with registered read
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      store_q[wr_addr] <= byte_in_i;
    end
    if (accept) begin
      rdata_q <= store_q[rd_idx_q];
    end
  end

  // size register and indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SizeReset;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
    end else if (cfg_we_i) begin
      size_q   <= cfg_wdata_i;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
    end else if (accept) begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // first result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_ok_q  <= rd_ok;
      s1_status_q <= status_n;
      s1_fill_q   <= fill_wide[7:0];
      s1_space_q  <= space_wide[7:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_move) begin
      s2_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_byte_q   <= s1_rd_ok_q ? rdata_q : 8'd0;
      s2_status_q <= s1_status_q;
      s2_fill_q   <= s1_fill_q;
      s2_space_q  <= s1_space_q;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign byte_out_o    = s2_byte_q;
  assign status_o      = s2_status_q;
  assign fill_count_o  = s2_fill_q;
  assign space_count_o = s2_space_q;

  // assertions
  // a refused write leaves both indices in place
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && status_n == STAT_FULL)
      |=> ($stable(wr_idx_q) && $stable(rd_idx_q)))
    else $error("indices moved on a refused write");

  // indices stay inside the part of the store in use
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(wr_idx_q) < sz) && (CW'(rd_idx_q) < sz))
    else $error("index outside the store in use");

  // no item is taken when both result slots are full and stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("item taken with no result slot free");

endmodule : byte_ring_buffer_with_prepend
`default_nettype wire
